### src/dqp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqp_pkg
// Shared types and constants for the dotted-quad IPv4 text parser.
// ----------------------------------------------------------------------------
package dqp_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned   MAX_LEN_DEF     = 31;
  localparam logic [15:0]   FAMILY_INET_DEF = 16'd2;

  // Character codes
  localparam logic [7:0] DOT_CHAR   = 8'h2E;
  localparam logic [7:0] PLUS_CHAR  = 8'h2B;
  localparam logic [7:0] MINUS_CHAR = 8'h2D;
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] TAB_CHAR   = 8'h09;
  localparam logic [7:0] CR_CHAR    = 8'h0D;
  localparam logic [7:0] ZERO_CHAR  = 8'h30;
  localparam logic [7:0] NINE_CHAR  = 8'h39;

  // Value limits
  localparam int unsigned ACC_W      = 9;
  localparam logic [8:0]  OCTET_MAX  = 9'd255;
  localparam logic [8:0]  ACC_SAT    = 9'd256;
  localparam int unsigned NUM_OCTETS = 4;
  localparam int unsigned CNT_W      = 3;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_FAMILY    = 2'd2,
    ST_INVALID   = 2'd3
  } status_t;

  // Number reader phase, one-hot
  typedef enum logic [2:0] {
    PH_SKIP   = 3'b001,
    PH_DIGITS = 3'b010,
    PH_DONE   = 3'b100
  } phase_t;

  // Per-token reader state
  typedef struct packed {
    logic             in_tok;
    phase_t           phase;
    logic             neg;
    logic [ACC_W-1:0] acc;
  } tok_state_t;

  localparam tok_state_t TOK_RESET = '{in_tok: 1'b0, phase: PH_SKIP, neg: 1'b0, acc: '0};

  // Token close event towards the octet store
  typedef struct packed {
    logic       fire;
    logic       bad;
    logic [7:0] value;
  } tok_close_t;

endpackage

### src/dqp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqp_in_if / dqp_out_if
// Valid/ready channels for text characters in and parse results out.
// ----------------------------------------------------------------------------
interface dqp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  char_code;
  logic        is_end;
  logic [15:0] family;
  logic        missing_pointer;

  modport source (output valid, char_code, is_end, family, missing_pointer, input ready);
  modport sink   (input valid, char_code, is_end, family, missing_pointer, output ready);
endinterface

interface dqp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] address;

  modport source (output valid, status, address, input ready);
  modport sink   (input valid, status, address, output ready);
endinterface

### src/dqp_token_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqp_token_step
// Per-character update of the token reader: whitespace skip, sign, decimal
// accumulation with saturation, and the close event for a finished token.
// ----------------------------------------------------------------------------
module dqp_token_step import dqp_pkg::*; (
  input  tok_state_t cur,
  input  logic [7:0] char_code,
  input  logic       is_end,
  input  logic       tok_full,
  output tok_state_t nxt,
  output tok_close_t close
);

  logic             is_dot;
  logic             closing;
  logic             is_digit;
  logic             is_space;
  logic [3:0]       digit;
  logic [11:0]      acc_mul;
  tok_state_t       base;

  assign is_dot   = (char_code == DOT_CHAR);
  assign closing  = is_end || is_dot;
  assign is_digit = (char_code >= ZERO_CHAR) && (char_code <= NINE_CHAR);
  assign is_space = (char_code == SPACE_CHAR) ||
                    ((char_code >= TAB_CHAR) && (char_code <= CR_CHAR));
  assign digit    = 4'(char_code - ZERO_CHAR);
  // acc * 10 + digit, as two shifts and adds
  assign acc_mul  = {cur.acc, 3'b000} + {2'b00, cur.acc, 1'b0} + {8'h00, digit};

  // Range check on the token being closed
  assign close.fire  = closing && cur.in_tok && !tok_full;
  assign close.bad   = (cur.neg && (cur.acc != '0)) || (cur.acc > OCTET_MAX);
  assign close.value = cur.acc[7:0];

  always_comb begin
    // start a fresh token on the first character that is neither a dot nor a terminator
    base        = cur.in_tok ? cur : TOK_RESET;
    base.in_tok = 1'b1;
    nxt         = base;
    if (closing) begin
      nxt        = is_end ? TOK_RESET : cur;
      nxt.in_tok = 1'b0;
    end else begin
      unique case (base.phase)
        PH_SKIP: begin
          if (is_space) begin
            nxt.phase = PH_SKIP;
          end else if ((char_code == PLUS_CHAR) || (char_code == MINUS_CHAR)) begin
            nxt.neg   = (char_code == MINUS_CHAR);
            nxt.phase = PH_DIGITS;
          end else if (is_digit) begin
            nxt.acc   = {5'b00000, digit};
            nxt.phase = PH_DIGITS;
          end else begin
            nxt.phase = PH_DONE;
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            nxt.acc = (acc_mul > {3'b000, ACC_SAT}) ? ACC_SAT : acc_mul[ACC_W-1:0];
          end else begin
            nxt.phase = PH_DONE;
          end
        end
        PH_DONE: nxt.phase = PH_DONE;
        default: nxt.phase = PH_DONE;
      endcase
    end
  end

endmodule

### src/dotted_quad_ipv4_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dotted_quad_ipv4_parser
// Parses dotted-decimal IPv4 text, one character per item, into a status
// and a 32-bit address.
// ----------------------------------------------------------------------------
// The block takes one character item per clock cycle, sustained, and the
// terminator item as well; each item passes an input register and then the
// character logic, and a result is captured in the output register when its
// terminator leaves the input register. The output register lets the
// next string stream in while a result waits; only a second terminator
// stalls behind an untaken result. Status order: unsupported family, then
// missing pointer, then text longer than MAX_LEN, then bad format.
module dotted_quad_ipv4_parser import dqp_pkg::*; #(
  parameter int unsigned MAX_LEN     = MAX_LEN_DEF,
  parameter logic [15:0] FAMILY_INET = FAMILY_INET_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  dqp_in_if.sink   in_ch,
  dqp_out_if.source out_ch
);

  localparam int unsigned LEN_W = $clog2(MAX_LEN + 2);

  // Input register
  logic        stg_vld_r;
  logic [7:0]  stg_char_r;
  logic        stg_end_r;
  logic [15:0] stg_fam_r;
  logic        stg_miss_r;
  logic        stg_go;

  // Parse state
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             fail_r, fail_nxt;
  tok_state_t       tok_r, tok_nxt;
  tok_close_t       close;
  logic [7:0]       octet_r [NUM_OCTETS];
  logic [7:0]       octet_nxt [NUM_OCTETS];
  logic             tok_full;

  // Result register
  logic        res_vld_r;
  status_t     res_status_r, res_status_nxt;
  logic [31:0] res_addr_r, res_addr_nxt;

  // Advance unless a terminator would overwrite a waiting result
  assign stg_go      = stg_vld_r && (!stg_end_r || !res_vld_r || out_ch.ready);
  assign in_ch.ready = !stg_vld_r || stg_go;
  assign tok_full    = (cnt_r == CNT_W'(NUM_OCTETS));

  dqp_token_step u_step (
    .cur       (tok_r),
    .char_code (stg_char_r),
    .is_end    (stg_end_r),
    .tok_full  (tok_full),
    .nxt       (tok_nxt),
    .close     (close)
  );

  // Count characters; count, store and check closed tokens
  always_comb begin
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    fail_nxt  = fail_r;
    octet_nxt = octet_r;
    if (!stg_end_r && (len_r <= LEN_W'(MAX_LEN))) begin
      len_nxt = len_r + LEN_W'(1);
    end
    if (close.fire) begin
      if (close.bad) begin
        fail_nxt = 1'b1;
        cnt_nxt  = CNT_W'(NUM_OCTETS);
      end else begin
        octet_nxt[cnt_r[1:0]] = close.value;
        cnt_nxt               = cnt_r + CNT_W'(1);
      end
    end
  end

  // Resolve the result on the terminator
  always_comb begin
    res_addr_nxt = '0;
    priority if (stg_fam_r != FAMILY_INET) begin
      res_status_nxt = ST_FAMILY;
    end else if (stg_miss_r) begin
      res_status_nxt = ST_INVALID;
    end else if (len_r > LEN_W'(MAX_LEN)) begin
      res_status_nxt = ST_MALFORMED;
    end else if (fail_nxt || (cnt_nxt != CNT_W'(NUM_OCTETS))) begin
      res_status_nxt = ST_MALFORMED;
    end else begin
      res_status_nxt = ST_OK;
      res_addr_nxt   = {octet_nxt[0], octet_nxt[1], octet_nxt[2], octet_nxt[3]};
    end
  end

  // Capture accepted items
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      stg_vld_r <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      stg_char_r <= in_ch.char_code;
      stg_end_r  <= in_ch.is_end;
      stg_fam_r  <= in_ch.family;
      stg_miss_r <= in_ch.missing_pointer;
    end
  end

  // Update parse state; clear it after each terminator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      cnt_r  <= '0;
      fail_r <= 1'b0;
      tok_r  <= TOK_RESET;
    end else if (stg_go) begin
      tok_r <= tok_nxt;
      if (stg_end_r) begin
        len_r  <= '0;
        cnt_r  <= '0;
        fail_r <= 1'b0;
      end else begin
        len_r  <= len_nxt;
        cnt_r  <= cnt_nxt;
        fail_r <= fail_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stg_go) begin
      octet_r <= octet_nxt;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (stg_go && stg_end_r) begin
      res_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      res_vld_r <= 1'b0;
    end
    if (stg_go && stg_end_r) begin
      res_status_r <= res_status_nxt;
      res_addr_r   <= res_addr_nxt;
    end
  end

  assign out_ch.valid   = res_vld_r;
  assign out_ch.status  = res_status_r;
  assign out_ch.address = res_addr_r;

endmodule
